/* rtl/tsvci_pkg.sv */
// tsvci_pkg: shared types and constants for the TSV column integer extractor.
// Used by tsvci_cfg, tsvci_parse, the top level and the testbench; depends on nothing else.
package tsvci_pkg;

	// Row limit per file and the widths that follow from it
	localparam int MaxRows  = 65536;
	localparam int RowW     = $clog2(MaxRows + 1);
	localparam int RowNumW  = 16;
	localparam int RowExtW  = (RowW > RowNumW) ? RowW : RowNumW;

	localparam int ValW     = 32;
	localparam int AccExtW  = ValW + 6;
	localparam int ColW     = 5;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = ColW;

	localparam logic signed [ValW-1:0] IntMax = 32'sh7FFF_FFFF;
	localparam logic signed [ValW-1:0] IntMin = 32'sh8000_0000;

	// Character codes
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;

	localparam logic [ColW-1:0] ColCountReset  = 5'd2;
	localparam logic [ColW-1:0] ColSelectReset = 5'd2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_COLUMN_COUNT  = 2'd0,
		CFG_COLUMN_SELECT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_SKIP  = 2'd0,
		PH_FIELD = 2'd1,
		PH_WAIT  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic signed [ValW-1:0] value;
		logic [RowNumW-1:0]     row_number;
		logic                   overflowed;
		logic                   last;
	} out_item_t;

	typedef struct packed {
		logic [ColW-1:0] column_count;
		logic [ColW-1:0] column_select;
	} cfg_t;

	typedef struct packed {
		logic      emit;
		out_item_t item;
	} res_t;

	typedef struct packed {
		phase_t          phase;
		logic [RowW-1:0] rows_done;
	} status_t;

endpackage

/* rtl/tsv_column_integer_extractor.sv */
// tsv_column_integer_extractor: top level, input and result registers around the parser.
// Depends on tsvci_pkg, tsvci_cfg and tsvci_parse.
//
// Streams a tab-separated text file in, one byte per word, and returns the signed
// decimal integer of the selected column for each complete row, saturated to 32 bits.
// It sustains one byte per clock while the result register is not stalled; an accepted byte
// passes through the input register, then the parser step into the result register.
// The rate is set by the parser's row state, which is read and rewritten in each
// byte step. A byte flagged end_of_data closes the file: an unfinished row
// is dropped and the row count restarts. After the row limit the block stays silent
// until the next end_of_data. Configuration writes are always ready and must only be
// made while no byte is in flight.
module tsv_column_integer_extractor import tsvci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic      valid_s1;
	in_item_t  data_s1;
	logic      out_valid_s2;
	out_item_t out_data_s2;
	logic      adv;
	logic      step;
	logic      accept;
	cfg_t      cfg;
	res_t      res;
	status_t   status;

	assign cfg_ready = 1'b1;

	tsvci_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the result register can load when empty or being drained
	assign adv      = !out_valid_s2 || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	tsvci_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (data_s1),
		.cfg    (cfg),
		.res    (res),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || in_stall;
			if (adv)
				out_valid_s2 <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			data_s1 <= in_data;
		if (step && res.emit)
			out_data_s2 <= res.item;
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	// a held input word is kept until the parser takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(data_s1)))
		else $error("input word lost while result register blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		status.rows_done <= RowW'(MaxRows))
		else $error("row count beyond row limit");

	// a final result leaves the parser at a row start or stopped
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit && res.item.last) |=>
		(status.phase == PH_SKIP || status.phase == PH_DONE))
		else $error("parser not restarted after last row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && data_s1.end_of_data) |=> (status.rows_done == '0))
		else $error("row count not cleared at end of file");

endmodule

/* rtl/tsvci_cfg.sv */
// tsvci_cfg: column count and column select registers behind the write port.
// Depends on tsvci_pkg.
module tsvci_cfg import tsvci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_count  <= ColCountReset;
			cfg_q.column_select <= ColSelectReset;
		end else if (wr_en) begin
			case (wr_index)
				CFG_COLUMN_COUNT:  cfg_q.column_count  <= wr_data;
				CFG_COLUMN_SELECT: cfg_q.column_select <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tsvci_parse.sv */
// tsvci_parse: row parser state and the combinational byte step that updates it.
// Depends on tsvci_pkg; stepped by the top level once per registered word.
module tsvci_parse import tsvci_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	input  cfg_t     cfg,
	output res_t     res,
	output status_t  status
);

	phase_t                 phase_q, phase_d;
	logic [ColW-1:0]        tabs_q, tabs_d;
	logic                   started_q, started_d;
	logic                   neg_q, neg_d;
	logic signed [ValW-1:0] acc_q, acc_d;
	logic                   sat_q, sat_d;
	logic [RowW-1:0]        rows_q, rows_d;

	logic [ColW-1:0]           sel;
	logic [7:0]                stop_ch;
	logic [7:0]                b;
	logic                      in_field;
	logic                      emit;
	logic                      last;
	logic [RowW-1:0]           rows_inc;
	logic signed [AccExtW-1:0] acc_ext;
	logic signed [AccExtW-1:0] digit;
	logic signed [AccExtW-1:0] mac;
	logic signed [ValW-1:0]    neg_val;
	logic                      neg_sat;
	logic [RowExtW-1:0]        rows_ext;

	assign b        = item.data_byte;
	assign sel      = (cfg.column_select == '0) ? ColW'(1) : cfg.column_select;
	assign stop_ch  = (cfg.column_select == cfg.column_count) ? ChCr : ChTab;
	assign rows_inc = rows_q + RowW'(1);
	assign last     = item.end_of_data || (rows_inc >= RowW'(MaxRows));

	// acc * 10 + (byte - '0') as shifts and adds, wide enough not to wrap
	assign acc_ext = AccExtW'(acc_q);
	assign digit   = $signed(AccExtW'(b)) - $signed(AccExtW'(ChZero));
	assign mac     = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;

	// Next state
	always_comb begin
		phase_d   = phase_q;
		tabs_d    = tabs_q;
		started_d = started_q;
		neg_d     = neg_q;
		acc_d     = acc_q;
		sat_d     = sat_q;
		rows_d    = rows_q;
		in_field  = 1'b0;
		emit      = 1'b0;

		case (phase_q)
			PH_SKIP: begin
				if (({1'b0, tabs_q} + (ColW+1)'(1)) < {1'b0, sel}) begin
					if (b == ChTab)
						tabs_d = tabs_q + ColW'(1);
				end else begin
					in_field = 1'b1;
				end
			end
			PH_FIELD: in_field = 1'b1;
			PH_WAIT:  emit = (b == ChLf);
			default: ;
		endcase

		if (in_field) begin
			phase_d   = PH_FIELD;
			started_d = 1'b1;
			if (!started_q && b == ChMinus) begin
				neg_d = 1'b1;
			end else if (b == stop_ch) begin
				phase_d = PH_WAIT;
			end else if (mac > AccExtW'(IntMax)) begin
				acc_d = IntMax;
				sat_d = 1'b1;
			end else if (mac < AccExtW'(IntMin)) begin
				acc_d = IntMin;
				sat_d = 1'b1;
			end else begin
				acc_d = ValW'(mac);
			end
		end

		if (emit) begin
			phase_d   = (last && !item.end_of_data) ? PH_DONE : PH_SKIP;
			tabs_d    = '0;
			started_d = 1'b0;
			neg_d     = 1'b0;
			acc_d     = '0;
			sat_d     = 1'b0;
			rows_d    = rows_inc;
		end

		// end of file: back to a fresh file whatever happened above
		if (item.end_of_data) begin
			phase_d   = PH_SKIP;
			tabs_d    = '0;
			started_d = 1'b0;
			neg_d     = 1'b0;
			acc_d     = '0;
			sat_d     = 1'b0;
			rows_d    = '0;
		end
	end

	// Result
	always_comb begin
		neg_val  = -acc_q;
		neg_sat  = 1'b0;
		rows_ext = RowExtW'(rows_q);
		if (acc_q == IntMin) begin
			neg_val = IntMax;
			neg_sat = 1'b1;
		end
		res.emit            = emit;
		res.item.value      = neg_q ? neg_val : acc_q;
		res.item.row_number = rows_ext[RowNumW-1:0];
		res.item.overflowed = sat_q || (neg_q && neg_sat);
		res.item.last       = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			tabs_q    <= '0;
			started_q <= 1'b0;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			sat_q     <= 1'b0;
			rows_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			tabs_q    <= tabs_d;
			started_q <= started_d;
			neg_q     <= neg_d;
			acc_q     <= acc_d;
			sat_q     <= sat_d;
			rows_q    <= rows_d;
		end
	end

	assign status.phase     = phase_q;
	assign status.rows_done = rows_q;

endmodule

/* test/tb_tsv_column_integer_extractor.sv */
`timescale 1ns / 1ps
// tb_tsv_column_integer_extractor: self-checking testbench for the TSV column integer extractor.
// Needs tsvci_pkg and the top level; predicts every row value in-bench and checks it on the
// result channel while both channels idle and stall at random.
module tb_tsv_column_integer_extractor;
	import tsvci_pkg::*;

	localparam int QuietLimit   = 4000;
	localparam int RandomBytes  = 1650;
	localparam int ShownErrors  = 10;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	tsv_column_integer_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Parser state as the predictor sees it
	logic [ColW-1:0]        col_count;
	logic [ColW-1:0]        col_select;
	phase_t                 ph;
	logic [4:0]             tabs_seen;
	logic                   field_started;
	logic                   negative;
	logic signed [ValW-1:0] acc;
	logic                   saturated;
	logic [RowW-1:0]        rows_done;

	out_item_t expected_rows[$];
	int mismatches    = 0;
	int rows_checked  = 0;
	int bytes_sent    = 0;
	int files_closed  = 0;
	int reg_writes    = 0;
	int busy_pct      = 25;
	int stall_pct     = 25;
	int stall_left    = 0;
	int quiet_cycles  = 0;

	always #10 clk = ~clk;

	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	function automatic void clear_row();
		ph            = PH_SKIP;
		tabs_seen     = '0;
		field_started = 1'b0;
		negative      = 1'b0;
		acc           = '0;
		saturated     = 1'b0;
	endfunction

	// Advance the row parser by one byte; return 1 when the byte completes a row
	function automatic bit parse_byte(input logic [7:0] b, input logic eod,
			output out_item_t row);
		int         sel;
		logic [7:0] stop_ch;
		longint     t;
		bit         emit;
		bit         sat;
		bit         is_last;
		emit = 1'b0;
		row  = '0;
		sel  = (col_select == 0) ? 1 : int'(col_select);
		stop_ch = (col_select == col_count) ? ChCr : ChTab;
		if (ph == PH_SKIP) begin
			if (int'(tabs_seen) + 1 < sel) begin
				if (b == ChTab)
					tabs_seen = tabs_seen + 5'd1;
			end else begin
				ph = PH_FIELD;
			end
		end
		if (ph == PH_FIELD) begin
			if (!field_started && b == ChMinus) begin
				negative      = 1'b1;
				field_started = 1'b1;
			end else begin
				field_started = 1'b1;
				if (b == stop_ch) begin
					ph = PH_WAIT;
				end else begin
					// any byte that is not the stop counts as a digit, even a line feed
					t = longint'(acc) * 10 + longint'(b) - longint'(ChZero);
					if (t > longint'(IntMax)) begin
						t = longint'(IntMax);
						saturated = 1'b1;
					end else if (t < longint'(IntMin)) begin
						t = longint'(IntMin);
						saturated = 1'b1;
					end
					acc = t[ValW-1:0];
				end
			end
		end else if (ph == PH_WAIT) begin
			if (b == ChLf) begin
				t   = longint'(acc);
				sat = saturated;
				if (negative) begin
					t = -t;
					if (t > longint'(IntMax)) begin
						t   = longint'(IntMax);
						sat = 1'b1;
					end
				end
				rows_done = rows_done + 1'b1;
				is_last = eod || (rows_done >= MaxRows);
				row.value      = t[ValW-1:0];
				row.row_number = RowNumW'(rows_done - 1'b1);
				row.overflowed = sat;
				row.last       = is_last;
				emit = 1'b1;
				clear_row();
				// hold silent until the next end of file
				if (is_last && !eod)
					ph = PH_DONE;
			end
		end
		if (eod) begin
			clear_row();
			rows_done = '0;
		end
		return emit;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eod);
		int        gap;
		out_item_t row;
		gap = pick_gap(busy_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, end_of_data: eod};
		do @(posedge clk); while (in_stall !== 1'b0);
		bytes_sent++;
		if (eod)
			files_closed++;
		if (parse_byte(b, eod, row))
			expected_rows.push_back(row);
	endtask

	task automatic send_text(input string s, input bit eod_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eod_last && (i == s.len() - 1));
	endtask

	// Raw bytes, biased toward the characters the parser reacts to
	task automatic send_noise(input int n, input bit eod_last);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: b = ChTab;
				1: b = ChCr;
				2: b = ChLf;
				3: b = ChMinus;
				default: b = $urandom_range(0, 255);
			endcase
			send_byte(b, eod_last && (i == n - 1));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		// bytes that end no row may still be in the pipeline
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == CFG_COLUMN_COUNT)
			col_count = val;
		else
			col_select = val;
	endtask

	function automatic string filler_text();
		string s;
		s = "";
		repeat ($urandom_range(0, 3))
			s = {s, $sformatf("%c", $urandom_range(8'h20, 8'h7E))};
		return s;
	endfunction

	function automatic string number_text();
		int    pick;
		string s;
		pick = $urandom_range(0, 19);
		s = "";
		if (pick < 10)
			s = $sformatf("%0d", $urandom_range(0, 9999));
		else if (pick < 13)
			s = $sformatf("%0d", $signed($urandom));
		else if (pick < 15)
			repeat ($urandom_range(10, 14))
				s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		else if (pick < 17)
			case ($urandom_range(0, 3))
				0: s = "2147483647";
				1: s = "2147483648";
				2: s = "-2147483648";
				default: s = "-2147483649";
			endcase
		else
			s = filler_text();
		if (pick < 15 && $urandom_range(0, 3) == 0)
			s = {"-", s};
		return s;
	endfunction

	function automatic string make_row();
		int    ncol;
		int    pick;
		string s;
		ncol = (col_count == 0) ? 1 : int'(col_count);
		pick = (col_select == 0) ? 1 : int'(col_select);
		s = "";
		for (int c = 1; c <= ncol; c++) begin
			if (c > 1)
				s = {s, "\t"};
			s = {s, (c == pick) ? number_text() : filler_text()};
		end
		return {s, "\r\n"};
	endfunction

	task automatic test_reset_columns();
		// reset setting: two columns, second selected, so carriage return ends the field
		send_text("ab\t5\r\n", 1'b0);
		send_text("\t-12\r\n", 1'b0);
		send_text("x\t\r\n", 1'b0);
		send_text("q\t-\r\n", 1'b1);
	endtask

	task automatic test_saturation();
		set_reg(CFG_COLUMN_COUNT, 5'd1);
		set_reg(CFG_COLUMN_SELECT, 5'd1);
		send_text("2147483647\r\n", 1'b0);
		send_text("2147483648\r\n", 1'b0);
		send_text("-2147483648\r\n", 1'b0);
		// digits below '0' drive the sum to the lowest value, then negate it
		send_text("-////////////\r\n", 1'b0);
		send_text("////////////\r\n", 1'b1);
	endtask

	task automatic test_odd_columns();
		string s;
		set_reg(CFG_COLUMN_COUNT, 5'd3);
		set_reg(CFG_COLUMN_SELECT, 5'd0);
		send_text("7\tx\ty\r\n", 1'b0);
		set_reg(CFG_COLUMN_COUNT, 5'd0);
		send_text("-4\r\n", 1'b1);
		set_reg(CFG_COLUMN_COUNT, 5'd2);
		set_reg(CFG_COLUMN_SELECT, 5'd4);
		send_text("1\t2\r\n3\t4\r\n5\t6\r\n", 1'b1);
		set_reg(CFG_COLUMN_COUNT, 5'd31);
		set_reg(CFG_COLUMN_SELECT, 5'd31);
		s = "";
		repeat (30) s = {s, "\t"};
		send_text({s, "9\r\n"}, 1'b1);
	endtask

	task automatic test_early_lf_and_cut_rows();
		set_reg(CFG_COLUMN_COUNT, 5'd2);
		set_reg(CFG_COLUMN_SELECT, 5'd1);
		send_text("1\n2\tz\r\n", 1'b0);
		send_text("44\tzz", 1'b1);
		send_text("3\tz\r\n", 1'b0);
		send_text("5\tz\r", 1'b1);
		send_text("6\tz\r\n", 1'b1);
	endtask

	task automatic test_random_files();
		int    start_bytes;
		int    rows;
		int    r;
		int    cut;
		string s;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RandomBytes) begin
			if ($urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					set_reg(CFG_COLUMN_COUNT, ColW'($urandom_range(1, 4)));
				else if (r < 85)
					set_reg(CFG_COLUMN_COUNT, ColW'($urandom_range(5, 16)));
				else if (r < 93)
					set_reg(CFG_COLUMN_COUNT, ColW'($urandom_range(17, 31)));
				else
					set_reg(CFG_COLUMN_COUNT, 5'd0);
				r = $urandom_range(0, 99);
				if (r < 60)
					set_reg(CFG_COLUMN_SELECT,
						ColW'($urandom_range(1, (col_count == 0) ? 1 : col_count)));
				else if (r < 85)
					set_reg(CFG_COLUMN_SELECT, col_count);
				else if (r < 93)
					set_reg(CFG_COLUMN_SELECT, 5'd0);
				else
					set_reg(CFG_COLUMN_SELECT, ColW'($urandom_range(0, 31)));
			end
			case ($urandom_range(0, 2))
				0: busy_pct = 0;
				1: busy_pct = 10;
				default: busy_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 50;
			endcase
			rows = $urandom_range(1, 10);
			for (int i = 0; i < rows - 1; i++) begin
				if ($urandom_range(0, 99) < 85)
					send_text(make_row(), 1'b0);
				else
					send_noise($urandom_range(1, 8), 1'b0);
			end
			s = make_row();
			case ($urandom_range(0, 4))
				0, 1: send_text(s, 1'b1);
				2: begin
					cut = $urandom_range(1, s.len() - 1);
					send_text(s.substr(0, cut - 1), 1'b1);
				end
				3: begin
					send_text(s, 1'b0);
					send_noise(1, 1'b1);
				end
				default: send_text(s, 1'b0);
			endcase
		end
	endtask

	// Check each accepted result word against the oldest predicted row
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= ShownErrors)
					$display("%0t: unexpected row: value %0d row %0d ovf %0b last %0b",
						$realtime, out_data.value, out_data.row_number,
						out_data.overflowed, out_data.last);
			end else begin
				want = expected_rows.pop_front();
				rows_checked++;
				if (out_data.value !== want.value || out_data.row_number !== want.row_number
						|| out_data.overflowed !== want.overflowed
						|| out_data.last !== want.last) begin
					mismatches++;
					if (mismatches <= ShownErrors)
						$display("%0t: row %0d expected %0d/%0b/%0b got %0d/%0d/%0b/%0b",
							$realtime, want.row_number, want.value, want.overflowed,
							want.last, out_data.value, out_data.row_number,
							out_data.overflowed, out_data.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else
			stall_left = pick_gap(stall_pct);
		out_stall <= (stall_left > 0);
	end

	// Stop the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("%0t: timeout, %0d rows still expected", $realtime,
				expected_rows.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		col_count  = ColCountReset;
		col_select = ColSelectReset;
		clear_row();
		rows_done = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_columns();
		test_saturation();
		test_odd_columns();
		test_early_lf_and_cut_rows();
		test_random_files();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes over %0d closed files with %0d register writes",
			bytes_sent, files_closed, reg_writes);
		$display("Checked %0d rows, %0d bad, %0d never arrived",
			rows_checked, mismatches, expected_rows.size());
		if (mismatches == 0 && expected_rows.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
